### src/wt_nco_pkg.sv
// Package: types, codes and the sine quarter-wave table for the wavetable NCO.
package wt_nco_pkg;

    localparam int TABLE_BITS            = 8;
    localparam int SAMPLE_BITS           = 8;
    localparam int STEP_BITS             = 24;
    localparam int DEFAULT_FRACTION_BITS = 16;

    typedef enum logic [2:0] {
        WAVE_SINE   = 3'd0,
        WAVE_SQUARE = 3'd1,
        WAVE_RISE   = 3'd2,
        WAVE_FALL   = 3'd3,
        WAVE_CUSTOM = 3'd4
    } t_wave;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } t_opcode;

    typedef enum logic {
        CFG_PHASE_STEP  = 1'b0,
        CFG_WAVE_SELECT = 1'b1
    } t_cfg_index;

    localparam logic [SAMPLE_BITS-1:0] SQUARE_HIGH = 8'd127;
    localparam logic [SAMPLE_BITS-1:0] SINE_MID    = 8'd127;
    localparam logic [SAMPLE_BITS-1:0] SINE_MIRROR = 8'd254;
    localparam logic [6:0]             QUARTER     = 7'd64;

    // Lookup stage contents handed to the waveform shaper
    typedef struct packed {
        t_wave                   wave;
        logic [TABLE_BITS-1:0]   index;
        logic [SAMPLE_BITS-1:0]  custom;
    } t_shape_req;

    // floor(127.5 + 127.5*sin(pi*k/128)), k = 0..64
    localparam logic [SAMPLE_BITS-1:0] SINE_QUARTER [0:64] = '{
        8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149,
        8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
        8'd176, 8'd179, 8'd182, 8'd184, 8'd187, 8'd190, 8'd193, 8'd195,
        8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213, 8'd215,
        8'd217, 8'd219, 8'd221, 8'd224, 8'd226, 8'd228, 8'd229, 8'd231,
        8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd244,
        8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251,
        8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
        8'd255
    };

    // Full-period sine from the quarter table; lower half mirrors the upper
    function automatic logic [SAMPLE_BITS-1:0] sine_sample(input logic [TABLE_BITS-1:0] n);
        logic [6:0]             k;
        logic                   neg;
        logic [SAMPLE_BITS-1:0] q;
        logic [SAMPLE_BITS-1:0] s;
        neg = n[7];
        k   = n[6] ? (QUARTER - {1'b0, n[5:0]}) : {1'b0, n[5:0]};
        q   = SINE_QUARTER[k];
        if (k == 7'd0) begin
            s = SINE_MID;
        end else if (neg && k == QUARTER) begin
            s = '0;
        end else if (neg) begin
            s = SINE_MIRROR - q;
        end else begin
            s = q;
        end
        return s;
    endfunction

endpackage

### src/wt_nco_shape.sv
// Waveform shaper: maps a table index to the sample of the selected waveform.
module wt_nco_shape
    import wt_nco_pkg::*;
(
    input  t_shape_req              i_req,
    output logic [SAMPLE_BITS-1:0]  o_sample
);

    always_comb begin
        unique case (i_req.wave)
            WAVE_SINE:   o_sample = sine_sample(i_req.index);
            WAVE_SQUARE: o_sample = i_req.index[TABLE_BITS-1] ? '0 : SQUARE_HIGH;
            WAVE_RISE:   o_sample = i_req.index;
            WAVE_FALL:   o_sample = ~i_req.index;
            WAVE_CUSTOM: o_sample = i_req.custom;
            default:     o_sample = '0;
        endcase
    end

endmodule

### src/wavetable_nco.sv
// Top level: wavetable NCO with phase accumulator, custom table RAM and output register.
//
//  channel | signals                                         | dir
//  --------+-------------------------------------------------+-----
//  in      | i_in_valid o_in_stall i_opcode i_entry_index/value | in
//  out     | o_out_valid i_out_stall o_sample                | out
//  cfg     | i_cfg_valid o_cfg_ready i_cfg_index i_cfg_data  | in
//
//  One beat per cycle unless the input stalls; a tick's accept loads the table
//  read register; that moves to the output register once it is empty or unstalled.
//  Write beats update the custom table and produce no output beat.
//  Input stalls only when the lookup stage and output register are both full
//  and the output is stalled. Config is always ready.
//  Reset clears the accumulator, config and valids; custom table is not cleared.
module wavetable_nco
    import wt_nco_pkg::*;
#(
    parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_opcode,
    input  logic [TABLE_BITS-1:0]   i_entry_index,
    input  logic [SAMPLE_BITS-1:0]  i_entry_value,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [SAMPLE_BITS-1:0]  o_sample,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic                    i_cfg_index,
    input  logic [STEP_BITS-1:0]    i_cfg_data
);

    localparam int ACC_W = TABLE_BITS + FRACTION_BITS;

    logic [STEP_BITS-1:0]   r_phase_step;
    t_wave                  r_wave;
    logic [ACC_W-1:0]       r_phase_acc;
    logic [ACC_W-1:0]       n_phase_acc;
    logic [ACC_W-1:0]       w_step;
    logic [TABLE_BITS-1:0]  w_index;
    logic                   w_in_acc;
    logic                   w_tick;
    logic                   w_write;
    logic                   w_adv;

    logic [SAMPLE_BITS-1:0] r_custom_mem [0:(1<<TABLE_BITS)-1];

    logic                   r_s1_valid;
    t_shape_req             r_s1;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0] w_shaped;

    assign o_cfg_ready = 1'b1;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_tick     = w_in_acc && (i_opcode == OP_TICK);
    assign w_write    = w_in_acc && (i_opcode == OP_WRITE);
    assign w_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && r_out_valid && i_out_stall;

    assign w_step      = ACC_W'(r_phase_step);
    assign n_phase_acc = r_phase_acc + w_step;
    assign w_index     = n_phase_acc[ACC_W-1 -: TABLE_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_wave       <= WAVE_SINE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PHASE_STEP:  r_phase_step <= i_cfg_data;
                CFG_WAVE_SELECT: r_wave       <= t_wave'(i_cfg_data[2:0]);
                default:         r_phase_step <= r_phase_step;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc <= '0;
        end else if (w_tick) begin
            r_phase_acc <= n_phase_acc;
        end
    end

    // custom table RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_custom_mem[i_entry_index] <= i_entry_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_s1.custom <= r_custom_mem[w_index];
            r_s1.index  <= w_index;
            r_s1.wave   <= r_wave;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_tick) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    wt_nco_shape u_shape (
        .i_req    (r_s1),
        .o_sample (w_shaped)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sample <= w_shaped;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

`ifndef SYNTHESIS
    a_write_holds_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_write |=> $stable(r_phase_acc))
        else $error("phase moved on a table write");

    a_tick_fills_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> r_s1_valid)
        else $error("tick beat lost before lookup stage");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && o_out_valid))
        else $error("input stalled with room in the pipeline");

    a_lookup_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !o_out_valid) |=> o_out_valid)
        else $error("lookup stage did not move to output register");
`endif

endmodule

### verif/testbench.sv
// Testbench for wavetable_nco: directed table, then random ticks and table writes checked by a predictor.
module testbench;
    import wt_nco_pkg::*;

    localparam int   ACC_W         = TABLE_BITS + DEFAULT_FRACTION_BITS;
    localparam int   HOLD_CYCLES   = 40;
    localparam int   SETTLE_CYCLES = 4;
    localparam int   DRAIN_CYCLES  = 10;
    localparam int   LIMIT         = 200000;
    localparam int   PHASES        = 10;
    localparam int   PHASE_ITEMS   = 60;
    localparam int   HOLD_PHASE    = 3;
    localparam real  PI            = 3.14159265358979323846;
    localparam logic [2:0] WAVE_SPARE_LO = 3'd5;
    localparam logic [2:0] WAVE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic                   is_cfg;
        t_cfg_index             reg_idx;
        logic [STEP_BITS-1:0]   data;
        t_opcode                op;
        logic [TABLE_BITS-1:0]  addr;
        logic [SAMPLE_BITS-1:0] value;
        logic                   known;
        logic [SAMPLE_BITS-1:0] want;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_opcode;
    logic [TABLE_BITS-1:0]  i_entry_index;
    logic [SAMPLE_BITS-1:0] i_entry_value;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [SAMPLE_BITS-1:0] o_sample;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic                   i_cfg_index;
    logic [STEP_BITS-1:0]   i_cfg_data;

    logic [ACC_W-1:0]       phase_acc_q;
    logic [STEP_BITS-1:0]   step_q;
    logic [2:0]             wave_q;
    logic [SAMPLE_BITS-1:0] user_tab [0:255];
    logic [SAMPLE_BITS-1:0] sine_tab [0:255];
    logic [SAMPLE_BITS-1:0] samples_due [$];
    logic [2:0]             wave_order [0:4];
    t_row                   directed [$];
    int                     errors;
    int                     cycles;
    bit                     idle_on;
    bit                     hold_req;

    wavetable_nco uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sample      (o_sample),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        errors++;
    endtask

    // advance the accumulator one tick and look up the selected waveform
    function automatic logic [SAMPLE_BITS-1:0] advance_phase();
        logic [TABLE_BITS-1:0]  n;
        logic [SAMPLE_BITS-1:0] s;
        phase_acc_q = phase_acc_q + ACC_W'(step_q);
        n = phase_acc_q[ACC_W-1 -: TABLE_BITS];
        case (wave_q)
            WAVE_SINE:   s = sine_tab[n];
            WAVE_SQUARE: s = n[TABLE_BITS-1] ? '0 : SQUARE_HIGH;
            WAVE_RISE:   s = n;
            WAVE_FALL:   s = 8'd255 - n;
            WAVE_CUSTOM: s = user_tab[n];
            default:     s = '0;
        endcase
        return s;
    endfunction

    function automatic t_row cfg_row(input t_cfg_index r, input logic [STEP_BITS-1:0] d);
        t_row row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.reg_idx = r;
        row.data    = d;
        return row;
    endfunction

    function automatic t_row tick_row(input logic known, input logic [SAMPLE_BITS-1:0] want);
        t_row row;
        row = '0;
        row.op    = OP_TICK;
        row.addr  = 8'($urandom);
        row.value = 8'($urandom);
        row.known = known;
        row.want  = want;
        return row;
    endfunction

    function automatic t_row write_row(input logic [7:0] a, input logic [7:0] v);
        t_row row;
        row = '0;
        row.op    = OP_WRITE;
        row.addr  = a;
        row.value = v;
        return row;
    endfunction

    task automatic send_beat(input t_opcode op, input logic [7:0] addr,
                             input logic [7:0] value, input logic known,
                             input logic [7:0] want);
        logic [SAMPLE_BITS-1:0] s;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_entry_index <= addr;
        i_entry_value <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (op == OP_WRITE) begin
            user_tab[addr] = value;
        end else begin
            s = advance_phase();
            samples_due.push_back(known ? want : s);
        end
    endtask

    // only while idle: drain results and let any table write settle first
    task automatic write_reg(input t_cfg_index r, input logic [STEP_BITS-1:0] d);
        i_in_valid <= 1'b0;
        while (samples_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (r == CFG_PHASE_STEP) begin
            step_q = d;
        end else begin
            wave_q = d[2:0];
        end
    endtask

    always @(posedge i_clk) begin : sample_check
        logic [SAMPLE_BITS-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (samples_due.size() == 0) begin
                report_mismatch($sformatf("sample %0d with none expected", o_sample));
            end else begin
                want = samples_due.pop_front();
                if (o_sample !== want) begin
                    report_mismatch($sformatf("sample %0d, expected %0d", o_sample, want));
                end
            end
        end
    end

    initial begin : out_stall_drive
        int stall_left;
        stall_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req    = 1'b0;
                stall_left  = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left  = $urandom_range(0, 3);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        t_row                 row;
        logic [2:0]           w;
        logic [STEP_BITS-1:0] s;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_opcode      = OP_TICK;
        i_entry_index = '0;
        i_entry_value = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_PHASE_STEP;
        i_cfg_data    = '0;
        errors        = 0;
        cycles        = 0;
        idle_on       = 1'b0;
        hold_req      = 1'b0;
        phase_acc_q   = '0;
        step_q        = '0;
        wave_q        = WAVE_SINE;
        wave_order    = '{WAVE_SINE, WAVE_SQUARE, WAVE_RISE, WAVE_FALL, WAVE_CUSTOM};
        for (int n = 0; n < 256; n++) begin
            if (n == 64) begin
                sine_tab[n] = 8'd255;
            end else if (n == 192) begin
                sine_tab[n] = 8'd0;
            end else if (n % 128 == 0) begin
                sine_tab[n] = 8'd127;
            end else begin
                sine_tab[n] = 8'(int'($floor(127.5 + 127.5 * $sin(2.0 * PI * n / 256.0))));
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset state: sine, zero step, accumulator at zero
        directed.push_back(tick_row(1'b1, 8'd127));
        directed.push_back(write_row(8'd0, 8'd255));
        directed.push_back(write_row(8'd255, 8'd0));
        directed.push_back(cfg_row(CFG_WAVE_SELECT, STEP_BITS'(WAVE_CUSTOM)));
        directed.push_back(tick_row(1'b1, 8'd255));
        directed.push_back(cfg_row(CFG_PHASE_STEP, 24'hFF0000));
        directed.push_back(tick_row(1'b1, 8'd0));
        directed.push_back(write_row(8'h80, 8'h5A));
        directed.push_back(cfg_row(CFG_PHASE_STEP, 24'h810000));
        directed.push_back(tick_row(1'b1, 8'h5A));
        // write then read of the same entry
        directed.push_back(cfg_row(CFG_PHASE_STEP, 24'h000000));
        directed.push_back(write_row(8'h80, 8'h3C));
        directed.push_back(tick_row(1'b1, 8'h3C));
        directed.push_back(cfg_row(CFG_WAVE_SELECT, STEP_BITS'(WAVE_RISE)));
        directed.push_back(cfg_row(CFG_PHASE_STEP, 24'h010000));
        directed.push_back(tick_row(1'b1, 8'd129));
        directed.push_back(cfg_row(CFG_PHASE_STEP, 24'hFFFFFF));
        directed.push_back(tick_row(1'b0, '0));
        directed.push_back(tick_row(1'b0, '0));
        directed.push_back(cfg_row(CFG_WAVE_SELECT, STEP_BITS'(WAVE_FALL)));
        directed.push_back(tick_row(1'b0, '0));
        directed.push_back(cfg_row(CFG_WAVE_SELECT, STEP_BITS'(WAVE_SQUARE)));
        directed.push_back(cfg_row(CFG_PHASE_STEP, 24'h800000));
        directed.push_back(tick_row(1'b0, '0));
        directed.push_back(tick_row(1'b0, '0));
        // unused selects give zero
        directed.push_back(cfg_row(CFG_WAVE_SELECT, STEP_BITS'(WAVE_SPARE_LO)));
        directed.push_back(tick_row(1'b1, 8'd0));
        directed.push_back(cfg_row(CFG_WAVE_SELECT, STEP_BITS'(WAVE_SPARE_HI)));
        directed.push_back(tick_row(1'b1, 8'd0));
        directed.push_back(cfg_row(CFG_WAVE_SELECT, STEP_BITS'(WAVE_SINE)));
        directed.push_back(cfg_row(CFG_PHASE_STEP, 24'h400000));
        repeat (4) directed.push_back(tick_row(1'b0, '0));

        idle_on = 1'b1;
        foreach (directed[i]) begin
            row = directed[i];
            if (row.is_cfg) begin
                write_reg(row.reg_idx, row.data);
            end else begin
                send_beat(row.op, row.addr, row.value, row.known, row.want);
            end
        end

        // fill the whole custom table so any later read is defined
        for (int a = 0; a < 256; a++) begin
            send_beat(OP_WRITE, 8'(a), 8'($urandom), 1'b0, '0);
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p < 5) begin
                w = wave_order[p];
            end else if ($urandom_range(0, 3) == 0) begin
                w = 3'($urandom_range(WAVE_SPARE_LO, WAVE_SPARE_HI));
            end else begin
                w = wave_order[$urandom_range(0, 4)];
            end
            case ($urandom_range(0, 5))
                0:       s = '0;
                1:       s = '1;
                2:       s = STEP_BITS'($urandom_range(1, 24'h03FFFF));
                default: s = STEP_BITS'($urandom);
            endcase
            write_reg(CFG_WAVE_SELECT, STEP_BITS'(w));
            write_reg(CFG_PHASE_STEP, s);
            idle_on = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
            if (p == HOLD_PHASE) begin
                hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_beat(OP_WRITE, 8'($urandom), 8'($urandom), 1'b0, '0);
                end else begin
                    send_beat(OP_TICK, 8'($urandom), 8'($urandom), 1'b0, '0);
                end
            end
        end

        i_in_valid <= 1'b0;
        while (samples_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
